// ===== hdl/pfp_pkg.sv =====
package pfp_pkg;

    // Frame markers and limits
    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hAF;
    localparam logic [7:0] FUNC_MAX   = 8'hF1;
    localparam logic [7:0] FUNC_POSE  = 8'h01;
    localparam logic [7:0] LEN_LIMIT  = 8'd255;

    // Payload bytes that carry one pose
    localparam int POSE_BYTES = 8;
    localparam int IDX_W      = $clog2(POSE_BYTES);
    localparam int CNT_W      = $clog2(POSE_BYTES + 1);

    // Parser phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_FUNC    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CSUM    = 3'd5
    } t_phase;

    // Decoded pose result
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        rotation_bits;
    } t_pose;

endpackage

// ===== hdl/pfp_if.sv =====
// Received byte channel
interface pfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// Decoded pose channel
interface pfp_pose_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        rotation_bits;

    modport source (output valid, output pos_x, output pos_y, output rotation_bits,
                    input ready);
    modport sink (input valid, input pos_x, input pos_y, input rotation_bits,
                  output ready);
endinterface

// ===== hdl/pose_frame_parser_top.sv =====
// Output: a pose appears on o_pose in the cycle after its checksum word is accepted.
// Throughput: one byte word per cycle unless o_pose stalls; the parser state advances
// by one short update per word; the output register frees on the same edge it is taken.
// Reset: synchronous, active low; parser returns to idle, output goes invalid,
// and no byte is accepted while reset is held.
module pose_frame_parser_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pfp_byte_if.sink   i_byte,
    pfp_pose_if.source o_pose
);
    import pfp_pkg::*;

    logic  take;
    logic  hit;
    t_pose pose;
    logic  r_valid;
    t_pose r_pose;

    // Accept a word whenever the output register has room or is being drained
    assign i_byte.ready = i_rst_n && (!r_valid || o_pose.ready);
    assign take         = i_byte.valid && i_byte.ready;

    pfp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_rx_byte (i_byte.rx_byte),
        .o_hit     (hit),
        .o_pose    (pose)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (hit) begin
            r_valid <= 1'b1;
        end else if (o_pose.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit) r_pose <= pose;
    end

    assign o_pose.valid         = r_valid;
    assign o_pose.pos_x         = r_pose.pos_x;
    assign o_pose.pos_y         = r_pose.pos_y;
    assign o_pose.rotation_bits = r_pose.rotation_bits;

endmodule

// ===== hdl/pfp_core.sv =====
module pfp_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_rx_byte,
    output logic          o_hit,
    output pfp_pkg::t_pose o_pose
);
    import pfp_pkg::*;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_left, n_left;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_func, n_func;
    logic [7:0]       r_store [POSE_BYTES];
    logic             store_wr;

    // Next state of the parser
    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_count  = r_count;
        n_sum    = r_sum;
        n_func   = r_func;
        store_wr = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_rx_byte == HDR_FIRST) begin
                    n_sum   = i_rx_byte;
                    n_phase = PH_HDR2;
                end
            end
            PH_HDR2: begin
                if (i_rx_byte == HDR_SECOND) begin
                    n_sum   = r_sum + i_rx_byte;
                    n_phase = PH_FUNC;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_FUNC: begin
                if (i_rx_byte <= FUNC_MAX) begin
                    n_sum   = r_sum + i_rx_byte;
                    n_func  = i_rx_byte;
                    n_phase = PH_LEN;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_LEN: begin
                if (i_rx_byte < LEN_LIMIT) begin
                    n_sum   = r_sum + i_rx_byte;
                    n_left  = i_rx_byte;
                    n_count = '0;
                    n_phase = PH_PAYLOAD;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_PAYLOAD: begin
                // zero length lands here with nothing left: drop with this word
                if (r_left != 8'd0) begin
                    n_sum  = r_sum + i_rx_byte;
                    n_left = r_left - 8'd1;
                    // count saturates once the pose bytes are all in
                    if (r_count < CNT_W'(POSE_BYTES)) begin
                        n_count  = r_count + CNT_W'(1);
                        store_wr = 1'b1;
                    end
                    if (r_left == 8'd1) n_phase = PH_CSUM;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_CSUM: begin
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Result decode
    always_comb begin
        o_hit = i_take && (r_phase == PH_CSUM) && (r_sum == i_rx_byte) &&
                (r_func == FUNC_POSE) && (r_count == CNT_W'(POSE_BYTES));
        o_pose.pos_x         = $signed({r_store[0], r_store[1]});
        o_pose.pos_y         = $signed({r_store[2], r_store[3]});
        o_pose.rotation_bits = {r_store[4], r_store[5], r_store[6], r_store[7]};
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_left  <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_func  <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_func  <= n_func;
        end
    end

    // Payload store, no reset
    always_ff @(posedge i_clk) begin
        if (i_take && store_wr) r_store[r_count[IDX_W-1:0]] <= i_rx_byte;
    end

endmodule

// ===== hdl/pfp_checker.sv =====
module pfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_data
);

    // Pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // Stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_data))
        else $error("result payload changed while stalled");

    // Input stalls only behind a stalled result
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output occupancy");

    // A new result needs an accepted word the cycle before
    a_rose_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready))
        else $error("result without an accepted word");

    // Taken result with no word accepted leaves output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !(i_in_valid && i_in_ready)) |=> !i_out_valid)
        else $error("result repeated");

endmodule

bind pose_frame_parser_top pfp_checker u_pfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_pose.valid),
    .i_out_ready (o_pose.ready),
    .i_out_data  ({o_pose.pos_x, o_pose.pos_y, o_pose.rotation_bits})
);

// ===== test/pose_frame_parser_top_tb.sv =====
module pose_frame_parser_top_tb;
    import pfp_pkg::*;

    localparam int ITEM_TARGET  = 1600;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    localparam logic [15:0] EDGE_COORDS [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

    // Kinds of byte sequences offered to the parser
    typedef enum int {
        FR_POSE,
        FR_OTHER_FUNC,
        FR_SHORT,
        FR_LONG,
        FR_BAD_CSUM,
        FR_ZERO_LEN,
        FR_BROKEN,
        FR_NOISE
    } t_frame_kind;

    // Receiver ready patterns
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_HEAVY
    } t_rx_mode;

    // Frame tracker: follows the byte stream and queues the poses it yields
    class pose_scoreboard;
        t_phase     phase;
        logic [7:0] bytes_left;
        logic [7:0] payload_cnt;
        logic [7:0] csum_acc;
        logic [7:0] func_code;
        logic [7:0] payload_buf [POSE_BYTES];
        t_pose      pose_q [$];
        int         fail_count;
        int         words_seen;
        int         frames_closed;
        int         poses_checked;

        function new();
            phase         = PH_IDLE;
            bytes_left    = '0;
            payload_cnt   = '0;
            csum_acc      = '0;
            func_code     = '0;
            fail_count    = 0;
            words_seen    = 0;
            frames_closed = 0;
            poses_checked = 0;
        endfunction

        function void flag(string msg);
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        function int pending();
            return pose_q.size();
        endfunction

        // Advance the parser state by one accepted byte word
        function void note_byte(logic [7:0] b);
            t_pose p;
            words_seen++;
            case (phase)
                PH_IDLE: begin
                    if (b == HDR_FIRST) begin
                        csum_acc = b;
                        phase    = PH_HDR2;
                    end
                end
                PH_HDR2: begin
                    if (b == HDR_SECOND) begin
                        csum_acc += b;
                        phase     = PH_FUNC;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
                PH_FUNC: begin
                    if (b <= FUNC_MAX) begin
                        csum_acc += b;
                        func_code = b;
                        phase     = PH_LEN;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
                PH_LEN: begin
                    if (b < LEN_LIMIT) begin
                        csum_acc   += b;
                        bytes_left  = b;
                        payload_cnt = '0;
                        phase       = PH_PAYLOAD;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
                PH_PAYLOAD: begin
                    // zero length: this word drops the frame
                    if (bytes_left != 0) begin
                        csum_acc += b;
                        if (payload_cnt < POSE_BYTES) begin
                            payload_buf[payload_cnt[IDX_W-1:0]] = b;
                        end
                        payload_cnt++;
                        bytes_left--;
                        if (bytes_left == 0) begin
                            phase = PH_CSUM;
                        end
                    end else begin
                        phase = PH_IDLE;
                    end
                end
                PH_CSUM: begin
                    phase = PH_IDLE;
                    frames_closed++;
                    if (csum_acc == b && func_code == FUNC_POSE &&
                        payload_cnt >= POSE_BYTES) begin
                        p.pos_x         = {payload_buf[0], payload_buf[1]};
                        p.pos_y         = {payload_buf[2], payload_buf[3]};
                        p.rotation_bits = {payload_buf[4], payload_buf[5],
                                           payload_buf[6], payload_buf[7]};
                        pose_q.push_back(p);
                    end
                end
                default: begin
                    phase = PH_IDLE;
                end
            endcase
        endfunction

        // Compare one delivered pose with the oldest one pending
        function void check_pose(t_pose got);
            t_pose want;
            if (pose_q.size() == 0) begin
                flag($sformatf("pose x=%0d y=%0d rot=%h with no frame pending",
                               got.pos_x, got.pos_y, got.rotation_bits));
                return;
            end
            want = pose_q.pop_front();
            poses_checked++;
            if (got.pos_x !== want.pos_x) begin
                flag($sformatf("pos_x expected %0d got %0d", want.pos_x, got.pos_x));
            end
            if (got.pos_y !== want.pos_y) begin
                flag($sformatf("pos_y expected %0d got %0d", want.pos_y, got.pos_y));
            end
            if (got.rotation_bits !== want.rotation_bits) begin
                flag($sformatf("rotation_bits expected %h got %h",
                               want.rotation_bits, got.rotation_bits));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pfp_byte_if byte_ch ();
    pfp_pose_if pose_ch ();

    pose_frame_parser_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_pose  (pose_ch)
    );

    pose_scoreboard sb;

    logic [7:0]  frame_q [$];
    bit          gaps_on;
    int          burst_left;
    t_rx_mode    rx_mode;
    int          rx_tick;
    int          hold_left;
    int          holds_asked;
    int          holds_granted;
    int          idle_cycles;
    int          kind_seen [8];
    int          items_sent;
    int          frame_no;
    int          pressure_left;
    int          roll;
    t_frame_kind kind;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Receiver: ready pattern per mode, plus a long hold on request
    always @(negedge i_clk) begin
        if (holds_granted < holds_asked) begin
            holds_granted++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            pose_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:   pose_ch.ready <= 1'b1;
                RX_RANDOM:   pose_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: pose_ch.ready <= ((rx_tick % 7) < 4);
                default:     pose_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
        rx_tick++;
    end

    // Monitor and watchdog, sampled at the rising edge
    always @(posedge i_clk) begin : monitor
        t_pose got;
        bit    took;
        took = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (pose_ch.valid === 1'b1 && pose_ch.ready === 1'b1) begin
                got.pos_x         = pose_ch.pos_x;
                got.pos_y         = pose_ch.pos_y;
                got.rotation_bits = pose_ch.rotation_bits;
                sb.check_pose(got);
                took = 1'b1;
            end
            if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) begin
                sb.note_byte(byte_ch.rx_byte);
                took = 1'b1;
            end
        end
        idle_cycles = took ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: %0d cycles without a handshake, %0d poses pending",
                     idle_cycles, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [7:0] frame_sum();
        logic [7:0] s;
        s = '0;
        foreach (frame_q[i]) s += frame_q[i];
        return s;
    endfunction

    // Offer one byte word, with a random gap between bursts
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 6);
            @(negedge i_clk);
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        @(negedge i_clk);
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        if (burst_left > 0) burst_left--;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) push_byte(frame_q[i]);
    endtask

    // Build the byte sequence of one frame kind into frame_q
    task automatic make_frame(input t_frame_kind k);
        logic [7:0]  fn;
        logic [7:0]  b;
        logic [15:0] cx;
        logic [15:0] cy;
        int          len;
        frame_q.delete();
        fn  = FUNC_POSE;
        len = POSE_BYTES;
        case (k)
            FR_NOISE: begin
                repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
            end
            FR_BROKEN: begin
                frame_q.push_back(HDR_FIRST);
                case (kind_seen[FR_BROKEN] % 3)
                    0: begin
                        do b = 8'($urandom_range(0, 255)); while (b == HDR_SECOND);
                        frame_q.push_back(b);
                    end
                    1: begin
                        frame_q.push_back(HDR_SECOND);
                        frame_q.push_back(8'($urandom_range(FUNC_MAX + 1, 255)));
                    end
                    default: begin
                        frame_q.push_back(HDR_SECOND);
                        frame_q.push_back(8'($urandom_range(0, FUNC_MAX)));
                        frame_q.push_back(LEN_LIMIT);
                    end
                endcase
            end
            default: begin
                case (k)
                    FR_POSE: begin
                        if ($urandom_range(0, 9) >= 7) len = $urandom_range(9, 16);
                    end
                    FR_OTHER_FUNC: begin
                        if (kind_seen[FR_OTHER_FUNC] == 0) begin
                            fn = FUNC_MAX;
                        end else begin
                            do fn = 8'($urandom_range(0, FUNC_MAX)); while (fn == FUNC_POSE);
                        end
                        len = $urandom_range(1, 12);
                    end
                    FR_SHORT:    len = $urandom_range(1, POSE_BYTES - 1);
                    FR_LONG:     len = (kind_seen[FR_LONG] == 0) ? LEN_LIMIT - 1
                                                                 : $urandom_range(9, 40);
                    FR_BAD_CSUM: len = $urandom_range(POSE_BYTES, POSE_BYTES + 2);
                    default: begin
                        fn  = 8'($urandom_range(0, FUNC_MAX));
                        len = 0;
                    end
                endcase
                frame_q = {HDR_FIRST, HDR_SECOND, fn, 8'(len)};
                repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
                // pull x and y to edge values (extremes, zero, minus one) now and then
                if (k == FR_POSE && $urandom_range(0, 3) == 0) begin
                    cx = EDGE_COORDS[2'($urandom_range(0, 3))];
                    cy = EDGE_COORDS[2'($urandom_range(0, 3))];
                    frame_q[4] = cx[15:8];
                    frame_q[5] = cx[7:0];
                    frame_q[6] = cy[15:8];
                    frame_q[7] = cy[7:0];
                end
                if (k == FR_ZERO_LEN) begin
                    frame_q.push_back(8'($urandom_range(0, 255)));
                end else if (k == FR_BAD_CSUM) begin
                    frame_q.push_back(frame_sum() + 8'($urandom_range(1, 255)));
                end else begin
                    frame_q.push_back(frame_sum());
                end
            end
        endcase
        kind_seen[k]++;
    endtask

    initial begin
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = '0;
        pose_ch.ready   = 1'b0;
        i_rst_n         = 1'b0;
        gaps_on         = 1'b0;
        burst_left      = 0;
        rx_mode         = RX_ALWAYS;
        rx_tick         = 0;
        hold_left       = 0;
        holds_asked     = 0;
        holds_granted   = 0;
        idle_cycles     = 0;
        items_sent      = 0;
        frame_no        = 0;
        pressure_left   = 0;
        foreach (kind_seen[i]) kind_seen[i] = 0;
        sb = new();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme pose, header not retried, zero length, function too big
        frame_q = {HDR_FIRST, HDR_SECOND, FUNC_POSE, 8'd8,
                   8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF};
        frame_q.push_back(frame_sum());
        send_frame();
        frame_q = {HDR_FIRST, HDR_FIRST, HDR_SECOND};
        send_frame();
        frame_q = {HDR_FIRST, HDR_SECOND, FUNC_POSE, 8'd0, HDR_FIRST};
        send_frame();
        frame_q = {HDR_FIRST, HDR_SECOND, 8'hF2};
        send_frame();

        // Random frames; first pass goes through every kind once
        while (items_sent < ITEM_TARGET) begin
            if (frame_no % 40 == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            if (frame_no == 60) begin
                holds_asked++;
                pressure_left = 20;
                gaps_on       = 1'b0;
            end
            if (pressure_left > 0) begin
                kind = FR_POSE;
                pressure_left--;
            end else if (frame_no < 8) begin
                kind = t_frame_kind'(frame_no);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 55)      kind = FR_POSE;
                else if (roll < 63) kind = FR_OTHER_FUNC;
                else if (roll < 71) kind = FR_SHORT;
                else if (roll < 75) kind = FR_LONG;
                else if (roll < 83) kind = FR_BAD_CSUM;
                else if (roll < 89) kind = FR_ZERO_LEN;
                else if (roll < 94) kind = FR_BROKEN;
                else                kind = FR_NOISE;
            end
            make_frame(kind);
            send_frame();
            if (kind != FR_NOISE) items_sent += frame_q.size();
            frame_no++;
        end

        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d byte words in %0d frames, %0d closed, %0d poses checked.",
                 sb.words_seen, frame_no, sb.frames_closed, sb.poses_checked);
        $display("Every frame kind, bursty sending, four ready patterns, %0d-cycle hold.",
                 HOLD_CYCLES);
        if (sb.fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches in total", sb.fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/pfp_pkg.sv
hdl/pfp_if.sv
hdl/pfp_core.sv
hdl/pose_frame_parser_top.sv
hdl/pfp_checker.sv
test/pose_frame_parser_top_tb.sv
